>>> rtl/asrs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the serial ADC read sequencer.
// No dependencies; imported by asrs_core and adc_serial_read_sequencer.
package asrs_pkg;

    // Command words sent to the converter; bits 15 down to 5 go out.
    localparam logic [15:0] CMD_WORD_FIRST  = 16'h6040;
    localparam logic [15:0] CMD_WORD_SECOND = 16'h4040;
    localparam int unsigned CMD_MSB         = 15;
    localparam int unsigned CMD_LSB         = 5;
    localparam int unsigned CHAN_LSB        = 8;
    localparam int unsigned XFER_BITS       = CMD_MSB - CMD_LSB + 1;
    localparam int unsigned SAMPLE_BITS     = 10;

    localparam logic [3:0] BIT_LAST = 4'(XFER_BITS - 1);

    // Sequence step, one-hot.
    typedef enum logic [9:0] {
        PH_IDLE = 10'b00_0000_0001,
        PH_HI1  = 10'b00_0000_0010,
        PH_CKH1 = 10'b00_0000_0100,
        PH_CKL1 = 10'b00_0000_1000,
        PH_END1 = 10'b00_0001_0000,
        PH_LO2  = 10'b00_0010_0000,
        PH_HI2  = 10'b00_0100_0000,
        PH_CKH2 = 10'b00_1000_0000,
        PH_CKL2 = 10'b01_0000_0000,
        PH_END2 = 10'b10_0000_0000
    } asrs_phase_t;

    // Pin levels and flags produced for one tick.
    typedef struct packed {
        logic                   sclk;
        logic                   mosi;
        logic                   convst;
        logic                   busy;
        logic                   sample_valid;
        logic [SAMPLE_BITS-1:0] sample;
    } asrs_res_t;

endpackage

>>> rtl/asrs_core.sv
`timescale 1ns / 1ps
// Sequencer state and per-tick step logic for the serial ADC read.
// Depends on asrs_pkg.
module asrs_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic             start_req,
    input  logic [2:0]       channel,
    input  logic             miso_level,
    output asrs_pkg::asrs_res_t res
);
    import asrs_pkg::*;

    asrs_phase_t          phase_reg, phase_next;
    logic [3:0]           bit_count_reg, bit_count_next;
    logic [XFER_BITS-1:0] shift_out_reg, shift_out_next;
    logic [XFER_BITS-1:0] shift_in_reg, shift_in_next;
    logic [15:0]          first_word;

    assign first_word = CMD_WORD_FIRST | {5'b0, channel, 8'b0};

    always_comb
    begin
        res            = '0;
        res.convst     = 1'b1;
        res.busy       = 1'b1;
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_out_next = shift_out_reg;
        shift_in_next  = shift_in_reg;
        case (phase_reg)
            PH_HI1:  phase_next = PH_CKH1;
            PH_HI2:  phase_next = PH_CKH2;
            PH_CKH1, PH_CKH2:
            begin
                res.sclk   = 1'b1;
                res.mosi   = shift_out_reg[XFER_BITS-1];
                phase_next = (phase_reg == PH_CKH1) ? PH_CKL1 : PH_CKL2;
            end
            PH_CKL1, PH_CKL2:
            begin
                // sample data-in and advance both shifters
                res.mosi       = shift_out_reg[XFER_BITS-1];
                shift_in_next  = {shift_in_reg[XFER_BITS-2:0], miso_level};
                shift_out_next = {shift_out_reg[XFER_BITS-2:0], 1'b0};
                bit_count_next = bit_count_reg + 4'd1;
                if (phase_reg == PH_CKL1)
                    phase_next = (bit_count_reg == BIT_LAST) ? PH_END1 : PH_CKH1;
                else
                    phase_next = (bit_count_reg == BIT_LAST) ? PH_END2 : PH_CKH2;
            end
            PH_END1: phase_next = PH_LO2;
            PH_LO2:
            begin
                res.convst     = 1'b0;
                shift_out_next = CMD_WORD_SECOND[CMD_MSB:CMD_LSB];
                shift_in_next  = '0;
                bit_count_next = 4'd0;
                phase_next     = PH_HI2;
            end
            PH_END2:
            begin
                res.sample_valid = 1'b1;
                res.sample       = shift_in_reg[XFER_BITS-1:1];
                phase_next       = PH_IDLE;
            end
            default:
            begin
                if (start_req)
                begin
                    res.convst     = 1'b0;
                    shift_out_next = first_word[CMD_MSB:CMD_LSB];
                    shift_in_next  = '0;
                    bit_count_next = 4'd0;
                    phase_next     = PH_HI1;
                end
                else
                begin
                    res.busy   = 1'b0;
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= 4'd0;
            shift_out_reg <= '0;
            shift_in_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_out_reg <= shift_out_next;
            shift_in_reg  <= shift_in_next;
        end
    end

endmodule

>>> rtl/adc_serial_read_sequencer.sv
`timescale 1ns / 1ps
// Top level of the serial ADC read sequencer: handshake and result register.
// Depends on asrs_pkg and asrs_core.
//
//  channel | direction | handshake           | word carries
//  --------+-----------+---------------------+--------------------------------------
//  in      | to block  | in_valid / in_stall | start_req, channel, miso_level
//  out     | from block| out_valid/out_stall | sclk/mosi/convst levels, busy_res,
//          |           |                     | sample_valid, sample
//
// One input word is taken per cycle while in_stall is low; each yields exactly one
// output word in the following cycle, held in the result register, which loads the
// combinational asrs_core step result in the cycle the word is taken.
// A read spans 50 input words from the start tick to the final tick.
// Reset clears the sequence to idle and empties the result register.
// in_stall rises only when the result register is full and out_stall is high,
// so a new word enters in the same cycle the previous result drains.
module adc_serial_read_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       start_req,
    input  logic [2:0] channel,
    input  logic       miso_level,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       sclk_level,
    output logic       mosi_level,
    output logic       convst_level,
    output logic       busy_res,
    output logic       sample_valid,
    output logic [9:0] sample
);
    import asrs_pkg::*;

    logic      in_accept;
    asrs_res_t step_res;
    asrs_res_t res_reg;
    logic      out_valid_reg, out_valid_next;

    // Hold the input while a finished word waits downstream.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    asrs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (in_accept),
        .start_req  (start_req),
        .channel    (channel),
        .miso_level (miso_level),
        .res        (step_res)
    );

    // Load on accept; drop the valid once the word is taken and nothing new arrives.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            res_reg <= step_res;
    end

    assign out_valid    = out_valid_reg;
    assign sclk_level   = res_reg.sclk;
    assign mosi_level   = res_reg.mosi;
    assign convst_level = res_reg.convst;
    assign busy_res     = res_reg.busy;
    assign sample_valid = res_reg.sample_valid;
    assign sample       = res_reg.sample;

endmodule

>>> rtl/asrs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the serial ADC read sequencer, bound to the top level.
// Depends only on the top-level ports.
module asrs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       sclk_level,
    input logic       mosi_level,
    input logic       convst_level,
    input logic       busy_res,
    input logic       sample_valid,
    input logic [9:0] sample
);

    // A stalled output word holds its valid, sample, sample_valid and busy_res.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample)
            && $stable(sample_valid) && $stable(busy_res))
        else $error("output word changed while stalled");

    // A sample is only shown at the end of a busy sequence.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_valid |-> busy_res && convst_level && !sclk_level
            && !mosi_level)
        else $error("sample presented outside a read end tick");

    // The sample field is zero whenever no sample is presented.
    a_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sample_valid |-> sample == 10'd0)
        else $error("nonzero sample without sample_valid");

    // Idle ticks leave every pin at rest.
    a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> convst_level && !sclk_level && !mosi_level
            && !sample_valid)
        else $error("pins active while idle");

    // The clock never pulses during a convert-start low pulse.
    a_clk_convst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sclk_level |-> convst_level && busy_res)
        else $error("serial clock high during convert-start pulse or idle");

endmodule

bind adc_serial_read_sequencer asrs_checker u_asrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sclk_level   (sclk_level),
    .mosi_level   (mosi_level),
    .convst_level (convst_level),
    .busy_res     (busy_res),
    .sample_valid (sample_valid),
    .sample       (sample)
);

>>> tb/sv/adc_read_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the serial ADC read sequencer: predicts each output word from the taken input
// words and compares it with the delivered one. Depends on asrs_pkg.
module adc_read_checker
    import asrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        start_req,
    input  logic [2:0]  channel,
    input  logic        miso_level,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        sclk_level,
    input  logic        mosi_level,
    input  logic        convst_level,
    input  logic        busy_res,
    input  logic        sample_valid,
    input  logic [9:0]  sample,
    output int unsigned fail_count,
    output int unsigned pending
);

    // Own copy of the sequencer state.
    asrs_phase_t seq_phase;
    logic [3:0]  bits_done;
    logic [10:0] cmd_shift;
    logic [10:0] rx_shift;

    asrs_res_t   pin_words_due[$];
    asrs_res_t   next_pins;
    asrs_res_t   due_pins;
    int unsigned errors = 0;
    int unsigned held   = 0;
    int unsigned word_no = 0;

    assign fail_count = errors;
    assign pending    = held;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR: output word %0d, %s: got %0h, want %0h", word_no, what, got, want);
        errors++;
    endtask

    // Advance the pin sequence by one tick and return the levels it drives.
    task automatic step_pins(input logic req, input logic [2:0] ch, input logic miso,
                             output asrs_res_t pins);
        logic [15:0] cmd;
        pins        = '0;
        pins.convst = 1'b1;
        pins.busy   = 1'b1;
        case (seq_phase)
            PH_HI1:  seq_phase = PH_CKH1;
            PH_HI2:  seq_phase = PH_CKH2;
            PH_END1: seq_phase = PH_LO2;
            PH_CKH1, PH_CKH2:
            begin
                pins.sclk = 1'b1;
                pins.mosi = cmd_shift[10];
                seq_phase = (seq_phase == PH_CKH1) ? PH_CKL1 : PH_CKH2 == seq_phase ?
                            PH_CKL2 : PH_CKL1;
            end
            PH_CKL1, PH_CKL2:
            begin
                pins.mosi = cmd_shift[10];
                rx_shift  = {rx_shift[9:0], miso};
                cmd_shift = {cmd_shift[9:0], 1'b0};
                bits_done = bits_done + 4'd1;
                if (bits_done >= 4'(XFER_BITS))
                    seq_phase = (seq_phase == PH_CKL1) ? PH_END1 : PH_END2;
                else
                    seq_phase = (seq_phase == PH_CKL1) ? PH_CKH1 : PH_CKH2;
            end
            PH_LO2:
            begin
                pins.convst = 1'b0;
                cmd_shift   = CMD_WORD_SECOND[CMD_MSB:CMD_LSB];
                rx_shift    = '0;
                bits_done   = '0;
                seq_phase   = PH_HI2;
            end
            PH_END2:
            begin
                // The last bit received is not part of the sample.
                pins.sample_valid = 1'b1;
                pins.sample       = rx_shift[10:1];
                seq_phase         = PH_IDLE;
            end
            default:
            begin
                if (req)
                begin
                    cmd         = CMD_WORD_FIRST | (16'(ch) << CHAN_LSB);
                    pins.convst = 1'b0;
                    cmd_shift   = cmd[CMD_MSB:CMD_LSB];
                    rx_shift    = '0;
                    bits_done   = '0;
                    seq_phase   = PH_HI1;
                end
                else
                begin
                    pins.busy = 1'b0;
                    seq_phase = PH_IDLE;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_phase = PH_IDLE;
            bits_done = '0;
            cmd_shift = '0;
            rx_shift  = '0;
            pin_words_due.delete();
            held <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                step_pins(start_req, channel, miso_level, next_pins);
                pin_words_due.push_back(next_pins);
            end
            if (out_valid && !out_stall)
            begin
                if (pin_words_due.size() == 0)
                    report_mismatch("word with nothing expected, sample", 32'(sample), 0);
                else
                begin
                    due_pins = pin_words_due.pop_front();
                    if (sclk_level !== due_pins.sclk)
                        report_mismatch("sclk_level", 32'(sclk_level), 32'(due_pins.sclk));
                    if (mosi_level !== due_pins.mosi)
                        report_mismatch("mosi_level", 32'(mosi_level), 32'(due_pins.mosi));
                    if (convst_level !== due_pins.convst)
                        report_mismatch("convst_level", 32'(convst_level),
                                        32'(due_pins.convst));
                    if (busy_res !== due_pins.busy)
                        report_mismatch("busy_res", 32'(busy_res), 32'(due_pins.busy));
                    if (sample_valid !== due_pins.sample_valid)
                        report_mismatch("sample_valid", 32'(sample_valid),
                                        32'(due_pins.sample_valid));
                    if (sample !== due_pins.sample)
                        report_mismatch("sample", 32'(sample), 32'(due_pins.sample));
                end
                word_no++;
            end
            held <= pin_words_due.size();
        end
    end

endmodule

>>> tb/sv/tb_adc_serial_read_sequencer.sv
`timescale 1ns / 1ps
// Top of the serial ADC read sequencer testbench: clock, reset, input words and output stall.
// Depends on asrs_pkg, adc_serial_read_sequencer and adc_read_checker.
module tb_adc_serial_read_sequencer;
    import asrs_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_WORDS = 850;
    localparam int unsigned DRAIN_CYCLES = 8;
    // A read runs 50 ticks from start to the final tick.
    localparam int unsigned READ_TICKS   = 50;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        start_req    = 1'b0;
    logic [2:0]  channel      = '0;
    logic        miso_level   = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic        sclk_level;
    logic        mosi_level;
    logic        convst_level;
    logic        busy_res;
    logic        sample_valid;
    logic [9:0]  sample;
    int unsigned fail_count;
    int unsigned pending;

    // Idle rates in percent for the sending and the receiving side.
    int unsigned tx_idle_pct = 21;
    int unsigned rx_idle_pct = 74;
    int unsigned cycles      = 0;

    adc_serial_read_sequencer dut (.*);
    adc_read_checker          scoreboard (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver side: stall at random at the current rate; zero rate means take every word.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

    // Offer one input word and hold it until taken. Idle gaps come before the word, so
    // valid never drops while a word waits and the payload stays put under stall.
    task automatic send_word(input logic req, input logic [2:0] ch, input logic miso);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_req  <= req;
        channel    <= ch;
        miso_level <= miso;
        @(posedge clk);
        while (!(in_valid && !in_stall))
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned miso_mode;
        int unsigned k;
        logic        miso;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Idle ticks at both channel extremes and both data-in levels.
        send_word(1'b0, 3'd0, 1'b0);
        send_word(1'b0, 3'd7, 1'b1);
        // Start on the top channel with data-in held high, then keep requesting on
        // channel 0 while busy: those requests must be dropped and the channel kept.
        send_word(1'b1, 3'd7, 1'b1);
        repeat (21)
            send_word(1'b1, 3'd0, 1'b1);

        // Random part in three stretches: sender-light/receiver-heavy idling, then the
        // reverse, then back-to-back with no idling at all.
        k = 0;
        miso_mode = 0;
        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:       begin tx_idle_pct <= 21; rx_idle_pct <= 74; end
                1:       begin tx_idle_pct <= 74; rx_idle_pct <= 21; end
                default: begin tx_idle_pct <= 0;  rx_idle_pct <= 0;  end
            endcase
            for (int i = 0; i < RANDOM_WORDS / 3; i++)
            begin
                // Pick a data-in pattern about once per read: all low, all high or noise,
                // so samples hit both extremes as well as random values.
                if (k % READ_TICKS == 0)
                    miso_mode = $urandom_range(0, 3);
                case (miso_mode)
                    0:       miso = 1'b0;
                    1:       miso = 1'b1;
                    default: miso = 1'($urandom_range(0, 1));
                endcase
                send_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), miso);
                k++;
            end
        end
        in_valid <= 1'b0;

        // Let the checker count the last word, then drain what is still due.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
